### rtl/core/text_console_cell_writer_unit_defines.svh
// assertion macros for the text console cell writer
`ifndef TEXT_CONSOLE_CELL_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_CELL_WRITER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define TCW_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tcw assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define TCW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tcw assertion failed");

`endif

### rtl/core/tcw_pkg.sv
// shared constants, codes and control types of the text console cell writer
`default_nettype none
package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int CMD_W  = 2;
	localparam int CHAR_W = 8;
	localparam int COLF_W = 7;
	localparam int ROWF_W = 5;

	localparam logic [CMD_W-1:0] CMD_PUT  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;

	typedef struct packed {
		logic load;
		logic exec;
		logic capture;
		logic sweep;
	} tcw_cmd_t;

	typedef struct packed {
		logic is_read;
		logic need_scroll;
		logic sweep_row_end;
		logic sweep_all_end;
	} tcw_sts_t;

endpackage
`default_nettype wire

### rtl/core/tcw_ctrl.sv
// sequencer of the text console cell writer: clear pass, command steps, row scroll
`default_nettype none
module tcw_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire tcw_pkg::tcw_sts_t sts,
	output tcw_pkg::tcw_cmd_t     cmd,
	output logic                  busy,
	output logic                  done
);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_EXEC   = 3'd2;
	localparam logic [2:0] ST_READ   = 3'd3;
	localparam logic [2:0] ST_SCROLL = 3'd4;
	localparam logic [2:0] ST_RESP   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_all_end) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				priority if (sts.is_read) state_d = ST_READ;
				else if (sts.need_scroll) state_d = ST_SCROLL;
				else state_d = ST_RESP;
			end
			ST_READ: begin
				cmd.capture = 1'b1;
				state_d     = ST_RESP;
			end
			ST_SCROLL: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_row_end) state_d = ST_RESP;
			end
			ST_RESP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_RESP);

endmodule
`default_nettype wire

### rtl/core/tcw_datapath.sv
// cell store, cursor and scroll base of the text console cell writer
`default_nettype none
module tcw_datapath #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire tcw_pkg::tcw_cmd_t           cmd,
	output tcw_pkg::tcw_sts_t                sts,
	input  wire logic [tcw_pkg::CMD_W-1:0]   command,
	input  wire logic [tcw_pkg::CHAR_W-1:0]  char_code,
	input  wire logic [tcw_pkg::COLF_W-1:0]  column,
	input  wire logic [tcw_pkg::ROWF_W-1:0]  row,
	output logic [tcw_pkg::COLF_W-1:0]       cursor_col,
	output logic [tcw_pkg::ROWF_W-1:0]       cursor_line,
	output logic [tcw_pkg::CHAR_W-1:0]       cell_data
);

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int CELLS  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);

	localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

	// logical row to physical row of the circular store
	function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
			input logic [ROW_W-1:0] b);
		logic [ROW_W:0] s;
		s = {1'b0, r} + {1'b0, b};
		if (s >= (ROW_W+1)'(ROWS)) s = s - (ROW_W+1)'(ROWS);
		return s[ROW_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] pr,
			input logic [COL_W-1:0] c);
		return ADDR_W'(ADDR_W'(pr) * ADDR_W'(COLUMNS) + ADDR_W'(c));
	endfunction

	logic [tcw_pkg::CMD_W-1:0]  cmd_q;
	logic [tcw_pkg::CHAR_W-1:0] ch_q;
	logic [tcw_pkg::COLF_W-1:0] col_q;
	logic [tcw_pkg::ROWF_W-1:0] row_q;

	logic [COL_W-1:0] cur_col_q;
	logic [ROW_W-1:0] cur_row_q;
	logic [ROW_W-1:0] base_q;
	logic [COL_W-1:0] sweep_col_q;
	logic [ROW_W-1:0] sweep_row_q;
	logic             rd_ok_q;
	logic [tcw_pkg::CHAR_W-1:0] cell_data_q;

	logic [tcw_pkg::CHAR_W-1:0] mem [CELLS];
	logic [tcw_pkg::CHAR_W-1:0] mem_rd_q;
	logic                       mem_we;
	logic [ADDR_W-1:0]          mem_waddr;
	logic [tcw_pkg::CHAR_W-1:0] mem_wdata;
	logic [ADDR_W-1:0]          mem_raddr;

	logic [COL_W-1:0] nxt_col;
	logic [ROW_W-1:0] nxt_row;
	logic [COL_W-1:0] wr_col;
	logic [ROW_W-1:0] wr_row;
	logic [tcw_pkg::CHAR_W-1:0] wr_data;
	logic             wr_en;
	logic             advance;
	logic             need_scroll;
	logic             rd_ok;

	// next cursor and cell write for the held command
	always_comb begin
		nxt_col     = cur_col_q;
		nxt_row     = cur_row_q;
		wr_col      = cur_col_q;
		wr_row      = cur_row_q;
		wr_data     = '0;
		wr_en       = 1'b0;
		advance     = 1'b0;
		need_scroll = 1'b0;
		unique case (cmd_q)
			tcw_pkg::CMD_PUT: begin
				priority if (ch_q == tcw_pkg::CH_BACKSPACE) begin
					if (cur_col_q == '0) begin
						nxt_col = COL_LAST;
						if (cur_row_q != '0) nxt_row = cur_row_q - 1'b1;
					end else begin
						nxt_col = cur_col_q - 1'b1;
					end
					wr_en  = 1'b1;
					wr_col = nxt_col;
					wr_row = nxt_row;
				end else if (ch_q == tcw_pkg::CH_NEWLINE) begin
					advance = 1'b1;
				end else begin
					wr_en   = 1'b1;
					wr_data = ch_q;
					if (cur_col_q == COL_LAST) advance = 1'b1;
					else nxt_col = cur_col_q + 1'b1;
				end
			end
			tcw_pkg::CMD_SET: begin
				nxt_col = (8'(col_q) < 8'(COLUMNS)) ? COL_W'(col_q) : COL_LAST;
				nxt_row = (7'(row_q) < 7'(ROWS)) ? ROW_W'(row_q) : ROW_LAST;
			end
			default: begin
			end
		endcase
		if (advance) begin
			nxt_col = '0;
			if (cur_row_q == ROW_LAST) need_scroll = 1'b1;
			else nxt_row = cur_row_q + 1'b1;
		end
	end

	assign rd_ok = (cmd_q == tcw_pkg::CMD_READ) && (8'(col_q) < 8'(COLUMNS))
		&& (7'(row_q) < 7'(ROWS));

	assign mem_raddr = rd_ok ? cell_addr(phys_row(ROW_W'(row_q), base_q), COL_W'(col_q))
		: '0;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		if (cmd.sweep) begin
			mem_we    = 1'b1;
			mem_waddr = cell_addr(sweep_row_q, sweep_col_q);
		end else if (cmd.exec && wr_en) begin
			mem_we    = 1'b1;
			mem_waddr = cell_addr(phys_row(wr_row, base_q), wr_col);
			mem_wdata = wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		mem_rd_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			ch_q  <= char_code;
			col_q <= column;
			row_q <= row;
		end
		if (cmd.exec) begin
			rd_ok_q     <= rd_ok;
			cell_data_q <= '0;
		end
		if (cmd.capture) cell_data_q <= rd_ok_q ? mem_rd_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			base_q      <= '0;
			sweep_col_q <= '0;
			sweep_row_q <= '0;
		end else begin
			if (cmd.exec) begin
				cur_col_q <= nxt_col;
				cur_row_q <= nxt_row;
				if (need_scroll) begin
					// old top row becomes the new bottom row, cleared by the sweep
					base_q      <= (base_q == ROW_LAST) ? '0 : base_q + 1'b1;
					sweep_row_q <= base_q;
					sweep_col_q <= '0;
				end
			end
			if (cmd.sweep) begin
				if (sweep_col_q == COL_LAST) begin
					sweep_col_q <= '0;
					sweep_row_q <= (sweep_row_q == ROW_LAST) ? '0 : sweep_row_q + 1'b1;
				end else begin
					sweep_col_q <= sweep_col_q + 1'b1;
				end
			end
		end
	end

	assign sts.is_read       = (cmd_q == tcw_pkg::CMD_READ);
	assign sts.need_scroll   = need_scroll;
	assign sts.sweep_row_end = (sweep_col_q == COL_LAST);
	assign sts.sweep_all_end = (sweep_col_q == COL_LAST) && (sweep_row_q == ROW_LAST);

	assign cursor_col  = tcw_pkg::COLF_W'(cur_col_q);
	assign cursor_line = tcw_pkg::ROWF_W'(cur_row_q);
	assign cell_data   = cell_data_q;

endmodule
`default_nettype wire

### rtl/core/text_console_cell_writer_unit.sv
// Text console cell writer: a COLUMNS by ROWS character grid with a cursor.
// Command channel: start with command, char_code, column and row; the beat is
// taken on a rising edge with start high and busy low.
// Commands: put character (backspace and newline handled), set cursor
// (clamped to the grid), read cell (zero outside the grid).
// Result channel: done is high for one cycle with cursor_col, cursor_line and
// cell_data; the receiver takes it in that cycle and cannot stall it.
// Steps: after acceptance the command executes and done follows, with a capture
// step between them for a read (registered read of the cell array); a new
// command is taken the cycle after done, not before the last result.
// A put that moves past the last row scrolls: the grid is a circular array of
// rows, so only the new bottom row is cleared, in a sweep before done.
// Reset: cursor goes home and a clearing pass zeroes all COLUMNS*ROWS cells
// with busy high; the single write port of the cell array sets the length
// of this pass and of the scroll.
`default_nettype none
`include "text_console_cell_writer_unit_defines.svh"
module text_console_cell_writer_unit #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [tcw_pkg::CMD_W-1:0]   command,
	input  wire logic [tcw_pkg::CHAR_W-1:0]  char_code,
	input  wire logic [tcw_pkg::COLF_W-1:0]  column,
	input  wire logic [tcw_pkg::ROWF_W-1:0]  row,
	output logic                             done,
	output logic [tcw_pkg::COLF_W-1:0]       cursor_col,
	output logic [tcw_pkg::ROWF_W-1:0]       cursor_line,
	output logic [tcw_pkg::CHAR_W-1:0]       cell_data
);

	tcw_pkg::tcw_cmd_t dp_cmd;
	tcw_pkg::tcw_sts_t dp_sts;

	tcw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (dp_sts),
		.cmd    (dp_cmd),
		.busy   (busy),
		.done   (done)
	);

	tcw_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.sts         (dp_sts),
		.command     (command),
		.char_code   (char_code),
		.column      (column),
		.row         (row),
		.cursor_col  (cursor_col),
		.cursor_line (cursor_line),
		.cell_data   (cell_data)
	);

	// one result beat per command, never two in a row
	`TCW_ASSERT_NEXT(a_done_single, done, !done)
	// an accepted beat keeps the block busy until its result
	`TCW_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	// cursor column reported on a result lies in the grid
	`TCW_ASSERT_IMPL(a_cursor_in_grid, done, 8'(cursor_col) < 8'(COLUMNS))
	// the cursor only moves while a command is in flight
	`TCW_ASSERT_NEXT(a_cursor_hold, !busy && !start, $stable(cursor_col) && $stable(cursor_line))

endmodule
`default_nettype wire

### tb/text_console_cell_writer_unit_tb.sv
// self-checking testbench for the text console cell writer: directed and random commands
`default_nettype none
module text_console_cell_writer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_COLS = tcw_pkg::COLUMNS_DEF;
	localparam int NUM_ROWS = tcw_pkg::ROWS_DEF;
	localparam int N_RANDOM = 1850;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [tcw_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef logic [tcw_pkg::CMD_W-1:0]  cmd_t;
	typedef logic [tcw_pkg::CHAR_W-1:0] char_t;
	typedef logic [tcw_pkg::COLF_W-1:0] col_t;
	typedef logic [tcw_pkg::ROWF_W-1:0] row_t;

	// tracks grid and cursor, and holds the status each accepted command should return
	class console_tracker;
		typedef struct {
			col_t  x;
			row_t  y;
			char_t data;
		} console_status_t;

		char_t screen [NUM_COLS*NUM_ROWS];
		col_t  trk_col;
		row_t  trk_row;
		console_status_t expected_status[$];
		int errors;

		function new();
			foreach (screen[i]) screen[i] = '0;
			trk_col = '0;
			trk_row = '0;
			errors = 0;
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask

		function int pending();
			return expected_status.size();
		endfunction

		function void advance_line();
			trk_col = '0;
			if (int'(trk_row) + 1 >= NUM_ROWS) begin
				// scroll up one row, blank bottom row
				trk_row = row_t'(NUM_ROWS - 1);
				for (int i = 0; i < NUM_COLS*(NUM_ROWS-1); i++) screen[i] = screen[i+NUM_COLS];
				for (int i = NUM_COLS*(NUM_ROWS-1); i < NUM_COLS*NUM_ROWS; i++) screen[i] = '0;
			end else begin
				trk_row = trk_row + 1'b1;
			end
		endfunction

		function void write_char(char_t ch);
			if (ch == tcw_pkg::CH_BACKSPACE) begin
				if (trk_col == 0) begin
					trk_col = col_t'(NUM_COLS - 1);
					if (trk_row > 0) trk_row = trk_row - 1'b1;
				end else begin
					trk_col = trk_col - 1'b1;
				end
				screen[int'(trk_row)*NUM_COLS + int'(trk_col)] = '0;
			end else if (ch == tcw_pkg::CH_NEWLINE) begin
				advance_line();
			end else begin
				screen[int'(trk_row)*NUM_COLS + int'(trk_col)] = ch;
				if (int'(trk_col) + 1 >= NUM_COLS) advance_line();
				else trk_col = trk_col + 1'b1;
			end
		endfunction

		function void take_command(cmd_t cmd, char_t ch, col_t col, row_t rw);
			console_status_t st;
			st.data = '0;
			case (cmd)
				tcw_pkg::CMD_PUT: write_char(ch);
				tcw_pkg::CMD_SET: begin
					trk_col = (int'(col) < NUM_COLS) ? col : col_t'(NUM_COLS - 1);
					trk_row = (int'(rw) < NUM_ROWS) ? rw : row_t'(NUM_ROWS - 1);
				end
				tcw_pkg::CMD_READ: begin
					if (int'(col) < NUM_COLS && int'(rw) < NUM_ROWS)
						st.data = screen[int'(rw)*NUM_COLS + int'(col)];
				end
				default: ;
			endcase
			st.x = trk_col;
			st.y = trk_row;
			expected_status.push_back(st);
		endfunction

		task check_status(col_t x, row_t y, char_t data);
			console_status_t st;
			if (expected_status.size() == 0) begin
				report("result beat with nothing outstanding");
			end else begin
				st = expected_status.pop_front();
				if (x !== st.x)
					report($sformatf("cursor_col got %0d expected %0d", x, st.x));
				if (y !== st.y)
					report($sformatf("cursor_line got %0d expected %0d", y, st.y));
				if (data !== st.data)
					report($sformatf("cell_data got %0d expected %0d", data, st.data));
			end
		endtask
	endclass

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	cmd_t  command;
	char_t char_code;
	col_t  column;
	row_t  row;
	logic  done;
	col_t  cursor_col;
	row_t  cursor_line;
	char_t cell_data;

	console_tracker tracker;
	int idle_pct;
	int cycles;

	text_console_cell_writer_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.char_code   (char_code),
		.column      (column),
		.row         (row),
		.done        (done),
		.cursor_col  (cursor_col),
		.cursor_line (cursor_line),
		.cell_data   (cell_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL text_console_cell_writer_unit");
			$finish;
		end
	end

	// result beat checked before a new command beat is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) tracker.check_status(cursor_col, cursor_line, cell_data);
			if (start && !busy) tracker.take_command(command, char_code, column, row);
		end
	end

	// entered and left at a falling edge; start stays high if the next beat follows at once
	task send_command(cmd_t cmd, char_t ch, col_t col, row_t rw);
		int gap;
		gap = 0;
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 17);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		command = cmd;
		char_code = ch;
		column = col;
		row = rw;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	initial begin
		int sel;
		int pick;
		cmd_t  cmd;
		char_t ch;
		col_t  col;
		row_t  rw;

		tracker = new();
		cycles = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		command = tcw_pkg::CMD_PUT;
		char_code = '0;
		column = '0;
		row = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: grid limits, clamping, backspace wrap, scroll
		send_command(tcw_pkg::CMD_READ, 8'h00, 7'd0, 5'd0);
		send_command(tcw_pkg::CMD_READ, 8'h00, 7'd127, 5'd31);
		send_command(tcw_pkg::CMD_READ, 8'h00, 7'd80, 5'd0);
		send_command(tcw_pkg::CMD_READ, 8'h00, 7'd0, 5'd25);
		send_command(tcw_pkg::CMD_SET, 8'h00, 7'd127, 5'd31);
		send_command(tcw_pkg::CMD_SET, 8'h00, 7'd0, 5'd0);
		send_command(tcw_pkg::CMD_PUT, tcw_pkg::CH_BACKSPACE, 7'd0, 5'd0);
		send_command(tcw_pkg::CMD_PUT, 8'hFF, 7'd0, 5'd0);
		send_command(tcw_pkg::CMD_READ, 8'h00, 7'd79, 5'd0);
		send_command(tcw_pkg::CMD_PUT, tcw_pkg::CH_BACKSPACE, 7'd0, 5'd0);
		send_command(tcw_pkg::CMD_READ, 8'h00, 7'd79, 5'd0);
		send_command(tcw_pkg::CMD_PUT, 8'h00, 7'd0, 5'd0);
		send_command(tcw_pkg::CMD_PUT, tcw_pkg::CH_NEWLINE, 7'd0, 5'd0);
		send_command(tcw_pkg::CMD_SET, 8'h00, 7'd78, 5'd24);
		send_command(tcw_pkg::CMD_PUT, 8'h5A, 7'd0, 5'd0);
		send_command(tcw_pkg::CMD_PUT, 8'hA5, 7'd0, 5'd0);
		send_command(tcw_pkg::CMD_READ, 8'h00, 7'd78, 5'd23);
		send_command(tcw_pkg::CMD_READ, 8'h00, 7'd79, 5'd23);
		send_command(tcw_pkg::CMD_PUT, tcw_pkg::CH_NEWLINE, 7'd0, 5'd0);
		send_command(tcw_pkg::CMD_READ, 8'h00, 7'd78, 5'd22);
		send_command(CMD_UNUSED, 8'hFF, 7'd127, 5'd31);
		send_command(tcw_pkg::CMD_PUT, 8'h80, 7'd0, 5'd0);
		send_command(tcw_pkg::CMD_PUT, 8'h7F, 7'd0, 5'd0);
		send_command(tcw_pkg::CMD_READ, 8'h00, 7'd0, 5'd24);
		send_command(tcw_pkg::CMD_READ, 8'h00, 7'd79, 5'd24);

		for (int i = 0; i < N_RANDOM; i++) begin
			// idling comes and goes in phases, none in the last stretch
			if (i >= N_RANDOM - 250) idle_pct = 0;
			else if ((i / 150) % 3 == 0) idle_pct = 0;
			else if ((i / 150) % 3 == 1) idle_pct = 15;
			else idle_pct = 40;

			sel = $urandom_range(0, 99);
			col = col_t'($urandom_range(0, 127));
			rw  = row_t'($urandom_range(0, 31));
			ch  = char_t'($urandom_range(0, 255));
			if (sel < 60) begin
				cmd = tcw_pkg::CMD_PUT;
				pick = $urandom_range(0, 19);
				if (pick < 2) ch = tcw_pkg::CH_BACKSPACE;
				else if (pick < 4) ch = tcw_pkg::CH_NEWLINE;
			end else if (sel < 70) begin
				cmd = tcw_pkg::CMD_SET;
				if ($urandom_range(0, 7) != 0) begin
					col = col_t'($urandom_range(0, NUM_COLS - 1));
					// bottom row often, so puts keep scrolling
					if ($urandom_range(0, 2) == 0) rw = row_t'(NUM_ROWS - 1);
					else rw = row_t'($urandom_range(0, NUM_ROWS - 1));
				end
			end else if (sel < 95) begin
				cmd = tcw_pkg::CMD_READ;
				pick = $urandom_range(0, 9);
				if (pick > 0) col = col_t'($urandom_range(0, NUM_COLS - 1));
				// read near the cursor where the writes land
				if (pick >= 1 && pick <= 5) begin
					rw = tracker.trk_row;
					if ($urandom_range(0, 1) == 1 && rw > 0) rw = rw - 1'b1;
				end else if (pick > 5) begin
					rw = row_t'($urandom_range(0, NUM_ROWS - 1));
				end
			end else begin
				cmd = CMD_UNUSED;
			end
			send_command(cmd, ch, col, rw);
		end
		start = 1'b0;

		while (tracker.pending() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("PASS text_console_cell_writer_unit");
		end else begin
			$display("FAIL text_console_cell_writer_unit");
		end
		$finish;
	end
endmodule
`default_nettype wire
